// ===== hw/rtl/iirbp_pkg.sv =====
// Package for the fourth-order band-pass IIR filter.
// Holds widths, register codes, reset coefficients and shared types.
// No dependencies.
package iirbp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int HIST_DEPTH = 4;
    localparam int FRAC_BITS  = 20;
    localparam int ACC_W      = 48;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic signed [COEF_W-1:0] RST_NUM_OUTER  = 24'sd1048576;
    localparam logic signed [COEF_W-1:0] RST_NUM_INNER  = 24'sd0;
    localparam logic signed [COEF_W-1:0] RST_NUM_CENTER = -24'sd2097152;
    localparam logic signed [COEF_W-1:0] RST_FB         = 24'sd0;

    typedef enum logic [2:0] {
        REG_NUM_OUTER  = 3'd0,
        REG_NUM_INNER  = 3'd1,
        REG_NUM_CENTER = 3'd2,
        REG_FB_LAG1    = 3'd3,
        REG_FB_LAG2    = 3'd4,
        REG_FB_LAG3    = 3'd5,
        REG_FB_LAG4    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] num_outer;
        logic signed [COEF_W-1:0] num_inner;
        logic signed [COEF_W-1:0] num_center;
        logic signed [COEF_W-1:0] fb_lag1;
        logic signed [COEF_W-1:0] fb_lag2;
        logic signed [COEF_W-1:0] fb_lag3;
        logic signed [COEF_W-1:0] fb_lag4;
    } coef_t;

    typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] hist_t;

endpackage

// ===== hw/rtl/iirbp_if.sv =====
// Stream interfaces for the band-pass IIR filter: input and result words.
// Depends on iirbp_pkg.
interface iirbp_in_if;
    import iirbp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;

    modport source (output valid, output sample_in, output block_end, input ready);
    modport sink (input valid, input sample_in, input block_end, output ready);
endinterface

interface iirbp_out_if;
    import iirbp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== hw/rtl/iirbp_regs.sv =====
// APB-style coefficient register bank of the band-pass IIR filter.
// Depends on iirbp_pkg.
module iirbp_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iirbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [iirbp_pkg::DATA_W-1:0]  pwdata,
    output logic [iirbp_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output iirbp_pkg::coef_t              coef
);
    import iirbp_pkg::*;

    coef_t                    coef_reg;
    logic                     wr_en;
    logic [2:0]               idx;
    logic signed [COEF_W-1:0] wval;
    logic signed [COEF_W-1:0] rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign wval   = pwdata[COEF_W-1:0];
    assign coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.num_outer  <= RST_NUM_OUTER;
            coef_reg.num_inner  <= RST_NUM_INNER;
            coef_reg.num_center <= RST_NUM_CENTER;
            coef_reg.fb_lag1    <= RST_FB;
            coef_reg.fb_lag2    <= RST_FB;
            coef_reg.fb_lag3    <= RST_FB;
            coef_reg.fb_lag4    <= RST_FB;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_NUM_OUTER:  coef_reg.num_outer  <= wval;
                REG_NUM_INNER:  coef_reg.num_inner  <= wval;
                REG_NUM_CENTER: coef_reg.num_center <= wval;
                REG_FB_LAG1:    coef_reg.fb_lag1    <= wval;
                REG_FB_LAG2:    coef_reg.fb_lag2    <= wval;
                REG_FB_LAG3:    coef_reg.fb_lag3    <= wval;
                REG_FB_LAG4:    coef_reg.fb_lag4    <= wval;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_NUM_OUTER:  rval = coef_reg.num_outer;
            REG_NUM_INNER:  rval = coef_reg.num_inner;
            REG_NUM_CENTER: rval = coef_reg.num_center;
            REG_FB_LAG1:    rval = coef_reg.fb_lag1;
            REG_FB_LAG2:    rval = coef_reg.fb_lag2;
            REG_FB_LAG3:    rval = coef_reg.fb_lag3;
            REG_FB_LAG4:    rval = coef_reg.fb_lag4;
            default:        rval = '0;
        endcase
        prdata = DATA_W'(rval);
    end

endmodule

// ===== hw/rtl/iirbp_mac.sv =====
// Multiply-accumulate datapath of the band-pass IIR filter: seven products,
// rounding, shift and saturation. Depends on iirbp_pkg.
module iirbp_mac (
    input  logic signed [iirbp_pkg::SAMPLE_W-1:0] x,
    input  iirbp_pkg::hist_t                      xh,
    input  iirbp_pkg::hist_t                      yh,
    input  iirbp_pkg::coef_t                      coef,
    output logic signed [iirbp_pkg::SAMPLE_W-1:0] y
);
    import iirbp_pkg::*;

    localparam int SH_W = ACC_W - FRAC_BITS;

    logic signed [SAMPLE_W:0]          sum_outer;
    logic signed [SAMPLE_W:0]          sum_inner;
    logic signed [COEF_W+SAMPLE_W:0]   p_outer;
    logic signed [COEF_W+SAMPLE_W:0]   p_inner;
    logic signed [COEF_W+SAMPLE_W-1:0] p_center;
    logic signed [COEF_W+SAMPLE_W-1:0] p_fb1;
    logic signed [COEF_W+SAMPLE_W-1:0] p_fb2;
    logic signed [COEF_W+SAMPLE_W-1:0] p_fb3;
    logic signed [COEF_W+SAMPLE_W-1:0] p_fb4;
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-1:0]           rnd;
    logic signed [SH_W-1:0]            q;

    always_comb
    begin
        sum_outer = (SAMPLE_W+1)'(x) + (SAMPLE_W+1)'($signed(xh[3]));
        sum_inner = (SAMPLE_W+1)'($signed(xh[0])) + (SAMPLE_W+1)'($signed(xh[2]));
        p_outer   = coef.num_outer * sum_outer;
        p_inner   = coef.num_inner * sum_inner;
        p_center  = coef.num_center * $signed(xh[1]);
        p_fb1     = coef.fb_lag1 * $signed(yh[0]);
        p_fb2     = coef.fb_lag2 * $signed(yh[1]);
        p_fb3     = coef.fb_lag3 * $signed(yh[2]);
        p_fb4     = coef.fb_lag4 * $signed(yh[3]);
        acc = ACC_W'(p_outer) + ACC_W'(p_inner) + ACC_W'(p_center)
            + ACC_W'(p_fb1) + ACC_W'(p_fb2) + ACC_W'(p_fb3) + ACC_W'(p_fb4);
        rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
        q   = rnd[ACC_W-1:FRAC_BITS];
        if (q > SH_W'(32767))
            y = 16'sh7fff;
        else if (q < -SH_W'(32768))
            y = 16'sh8000;
        else
            y = q[SAMPLE_W-1:0];
    end

endmodule

// ===== hw/rtl/iir_bandpass_order4.sv =====
// Top level of the fourth-order direct-form-I band-pass IIR filter.
// Depends on iirbp_pkg, iirbp_if, iirbp_regs and iirbp_mac.
//
// Usage: audio words enter on din (sample_in, block_end) and filtered words
// leave on dout (sample_out, last_out), one result for every input word.
// Both channels use a valid/ready handshake.
// An accepted word is held in an input register; the whole filter sum is
// formed combinationally from it and the history registers and stored in the
// output register, from which the result word is offered on dout until the
// receiver takes it. Throughput is one word per cycle while the receiver
// does not stall, set by the combinational recursive multiply-accumulate
// that closes the output feedback loop.
// When the receiver stalls, the result waits in the output register and one
// more word can wait in the input register; din.ready then drops.
// Reset clears both histories and valid flags, sets numerator 1, 0, -2, 0, 1
// and zero feedback. Coefficients are written over the APB-style port while
// the filter is idle; this binds the user, the block does not enforce it.
module iir_bandpass_order4 (
    input  logic                          clk,
    input  logic                          rst_n,
    iirbp_in_if.sink                      din,
    iirbp_out_if.source                   dout,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iirbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [iirbp_pkg::DATA_W-1:0]  pwdata,
    output logic [iirbp_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import iirbp_pkg::*;

    coef_t                      coef;
    logic                       in_vld_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic                       out_vld_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       y_last_reg;
    hist_t                      xh_reg;
    hist_t                      yh_reg;
    logic signed [SAMPLE_W-1:0] y_next;
    logic                       advance;
    logic                       take_in;

    iirbp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    iirbp_mac u_mac (
        .x    (x_reg),
        .xh   (xh_reg),
        .yh   (yh_reg),
        .coef (coef),
        .y    (y_next)
    );

    assign advance         = in_vld_reg && (!out_vld_reg || dout.ready);
    assign din.ready       = !in_vld_reg || advance;
    assign take_in         = din.valid && din.ready;
    assign dout.valid      = out_vld_reg;
    assign dout.sample_out = y_reg;
    assign dout.last_out   = y_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            xh_reg      <= '0;
            yh_reg      <= '0;
        end
        else
        begin
            if (take_in)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                xh_reg      <= {xh_reg[HIST_DEPTH-2:0], x_reg};
                yh_reg      <= {yh_reg[HIST_DEPTH-2:0], y_next};
            end
            else if (dout.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            x_reg    <= din.sample_in;
            last_reg <= din.block_end;
        end
        if (advance)
        begin
            y_reg      <= y_next;
            y_last_reg <= last_reg;
        end
    end

endmodule
